@@ rtl/core/itre_pkg.sv @@
// ----------------------------------------------------------------------------
// itre_pkg
// Types and constants shared by the instruction trace record encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package itre_pkg;

  localparam logic [7:0] CtrlPacketEnd = 8'h02;
  localparam logic [7:0] CtrlNormal    = 8'h01;
  localparam logic [7:0] CycleEscape   = 8'hFF;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned CycleW   = 64;
  localparam int unsigned RecBytes = 15;
  localparam int unsigned LenW     = $clog2(RecBytes + 1);

  localparam logic [LenW-1:0] ShortLen = LenW'(7);
  localparam logic [LenW-1:0] LongLen  = LenW'(RecBytes);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic              packet_end;
    logic [7:0]        core_id;
    logic [AddrW-1:0]  addr_delta;
    logic [CycleW-1:0] cycle_delta;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/instruction_trace_record_encoder.sv @@
// ----------------------------------------------------------------------------
// instruction_trace_record_encoder
// Encodes decoded instructions into delta-coded byte trace records.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------
//   in       | input     | in_valid_i/in_stall_o | core_id, instr_address,
//            |           |                       | packet_end, cycle_number
//   out      | output    | out_valid_o/out_stall_i | out_byte, record_last
//
// One byte leaves per cycle unless the output stalls: a record is 7 bytes,
// or 15 when the cycle delta needs the long form; the byte serializer sets
// this rate. Records follow each other with no gap; a two-entry queue lets
// new instructions enter while a record is still being sent.
// Reset clears the last address and last cycle to zero and empties the queue.
// A stall on the output holds the current byte; the input stalls once the
// queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module instruction_trace_record_encoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [7:0]                  core_id_i,
  input  wire logic [itre_pkg::AddrW-1:0]  instr_address_i,
  input  wire logic                        packet_end_i,
  input  wire logic [itre_pkg::CycleW-1:0] cycle_number_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [7:0]                  out_byte_o,
  output      logic                        record_last_o
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  itre_pkg::entry_t push_entry;
  itre_pkg::entry_t pop_entry;

  itre_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .core_id_i       (core_id_i),
    .instr_address_i (instr_address_i),
    .packet_end_i    (packet_end_i),
    .cycle_number_i  (cycle_number_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (push_entry)
  );

  itre_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  itre_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (pop_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .record_last_o (record_last_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/itre_front.sv @@
// ----------------------------------------------------------------------------
// itre_front
// Accepts instructions, forms address and cycle deltas, tracks last values.
// ----------------------------------------------------------------------------
`default_nettype none

module itre_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [7:0]                    core_id_i,
  input  wire logic [itre_pkg::AddrW-1:0]    instr_address_i,
  input  wire logic                          packet_end_i,
  input  wire logic [itre_pkg::CycleW-1:0]   cycle_number_i,
  input  wire logic                          q_full_i,
  output      logic                          q_push_o,
  output      itre_pkg::entry_t              q_entry_o
);

  logic [itre_pkg::AddrW-1:0]  last_addr_q;
  logic [itre_pkg::CycleW-1:0] last_cycle_q;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_entry_o.packet_end  = packet_end_i;
    q_entry_o.core_id     = core_id_i;
    q_entry_o.addr_delta  = instr_address_i - last_addr_q;
    q_entry_o.cycle_delta = cycle_number_i - last_cycle_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_addr_q  <= '0;
      last_cycle_q <= '0;
    end else if (q_push_o) begin
      last_addr_q  <= instr_address_i;
      last_cycle_q <= cycle_number_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/itre_queue.sv @@
// ----------------------------------------------------------------------------
// itre_queue
// Short FIFO between the front and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module itre_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire itre_pkg::entry_t entry_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic             valid_o,
  output      itre_pkg::entry_t entry_o
);

  itre_pkg::entry_t                 mem_q [itre_pkg::QDepth];
  logic [itre_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [itre_pkg::QCntW-1:0]       count_q;

  assign full_o  = count_q == itre_pkg::QCntW'(itre_pkg::QDepth);
  assign valid_o = count_q != '0;
  assign entry_o = mem_q[rd_ptr_q];

  function automatic logic [itre_pkg::QPtrW-1:0] next_ptr(
    input logic [itre_pkg::QPtrW-1:0] ptr
  );
    if (ptr == itre_pkg::QPtrW'(itre_pkg::QDepth - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/itre_back.sv @@
// ----------------------------------------------------------------------------
// itre_back
// Builds the byte record from a queued entry and serializes it one byte per
// cycle, unless the output stalls, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itre_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire itre_pkg::entry_t q_entry_i,
  output      logic             q_pop_o,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      logic [7:0]       out_byte_o,
  output      logic             record_last_o
);

  logic [7:0]                rec_q [itre_pkg::RecBytes];
  logic [7:0]                rec_d [itre_pkg::RecBytes];
  logic [itre_pkg::LenW-1:0] rem_q, rem_d;
  logic                      busy_q, busy_d;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                out_byte_q, out_byte_d;
  logic                      out_last_q, out_last_d;

  logic                      out_free;
  logic                      emit;
  logic                      neg;
  logic [itre_pkg::AddrW-1:0] mag;
  logic [itre_pkg::AddrW-1:0] code;
  logic                      long_form;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = busy_q && out_free;
  assign q_pop_o  = q_valid_i && (!busy_q || (emit && rem_q == itre_pkg::LenW'(1)));

  // sign fold of the address delta, long form select for the cycle delta
  always_comb begin
    neg       = q_entry_i.addr_delta[itre_pkg::AddrW-1];
    mag       = neg ? (~q_entry_i.addr_delta + 1'b1) : q_entry_i.addr_delta;
    code      = {mag[itre_pkg::AddrW-2:0], neg};
    long_form = (q_entry_i.cycle_delta[itre_pkg::CycleW-1:8] != '0)
             || (q_entry_i.cycle_delta[7:0] == itre_pkg::CycleEscape);
  end

  always_comb begin
    rec_d       = rec_q;
    rem_d       = rem_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (out_free) begin
      out_valid_d = 1'b0;
    end

    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = rec_q[0];
      out_last_d  = rem_q == itre_pkg::LenW'(1);
      for (int i = 0; i < itre_pkg::RecBytes - 1; i++) begin
        rec_d[i] = rec_q[i+1];
      end
      rec_d[itre_pkg::RecBytes-1] = '0;
      rem_d  = rem_q - 1'b1;
      busy_d = rem_q != itre_pkg::LenW'(1);
    end

    if (q_pop_o) begin
      busy_d   = 1'b1;
      rec_d[0] = q_entry_i.packet_end ? itre_pkg::CtrlPacketEnd : itre_pkg::CtrlNormal;
      rec_d[1] = q_entry_i.core_id;
      for (int i = 0; i < 4; i++) begin
        rec_d[2+i] = code[8*i +: 8];
      end
      for (int i = 7; i < itre_pkg::RecBytes; i++) begin
        rec_d[i] = '0;
      end
      if (long_form) begin
        rec_d[6] = itre_pkg::CycleEscape;
        for (int i = 0; i < 8; i++) begin
          rec_d[7+i] = q_entry_i.cycle_delta[8*i +: 8];
        end
        rem_d = itre_pkg::LongLen;
      end else begin
        rec_d[6] = q_entry_i.cycle_delta[7:0];
        rem_d    = itre_pkg::ShortLen;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q      <= rec_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign record_last_o = out_last_q;

endmodule

`default_nettype wire
